@@ hw/rtl/urf_pkg.sv @@
// Shared types, constants, the swap map and the control store for the UDP port reflector.
`default_nettype none

package urf_pkg;

  localparam int unsigned HDR_LEN = 42;
  localparam int unsigned POS_W = $clog2(HDR_LEN);
  localparam logic [7:0] UDP_PROTO = 8'd17;
  localparam logic [15:0] PORT_RESET = 16'd55007;

  // Byte offsets of the header fields that the verdict looks at.
  localparam logic [POS_W-1:0] OFS_PROTO = POS_W'(23);
  localparam logic [POS_W-1:0] OFS_DPORT_HI = POS_W'(36);
  localparam logic [POS_W-1:0] OFS_DPORT_LO = POS_W'(37);
  localparam logic [POS_W-1:0] OFS_LAST = POS_W'(HDR_LEN - 1);

  // Configuration port: one register, word index taken from paddr[2].
  localparam int unsigned CFG_AW = 3;
  localparam logic CFG_IDX_REFLECT_PORT = 1'b0;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       frame_end;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_end;
    logic       verdict;
  } out_item_t;

  // Sequencer program addresses.
  typedef logic [1:0] step_t;
  localparam step_t STEP_COLLECT = 2'd0;
  localparam step_t STEP_READ = 2'd1;
  localparam step_t STEP_EMIT = 2'd2;

  typedef enum logic [1:0] {
    JC_ALWAYS = 2'd0,
    JC_GO     = 2'd1,
    JC_LAST   = 2'd2
  } jcond_t;

  typedef struct packed {
    logic   accept;
    logic   mem_rd;
    logic   emit;
    jcond_t cond;
    step_t  tgt_true;
    step_t  tgt_false;
  } ctrl_word_t;

  typedef struct packed {
    logic go;
    logic last;
    logic out_free;
  } seq_status_t;

  function automatic ctrl_word_t ucode_rom(step_t addr);
    ctrl_word_t w;
    w = '{accept: 1'b1, mem_rd: 1'b0, emit: 1'b0, cond: JC_GO,
          tgt_true: STEP_READ, tgt_false: STEP_COLLECT};
    unique case (addr)
      STEP_COLLECT: w = '{accept: 1'b1, mem_rd: 1'b0, emit: 1'b0, cond: JC_GO,
                          tgt_true: STEP_READ, tgt_false: STEP_COLLECT};
      STEP_READ:    w = '{accept: 1'b0, mem_rd: 1'b1, emit: 1'b0, cond: JC_ALWAYS,
                          tgt_true: STEP_EMIT, tgt_false: STEP_EMIT};
      STEP_EMIT:    w = '{accept: 1'b0, mem_rd: 1'b0, emit: 1'b1, cond: JC_LAST,
                          tgt_true: STEP_COLLECT, tgt_false: STEP_READ};
      default:      w = '{accept: 1'b0, mem_rd: 1'b0, emit: 1'b0, cond: JC_ALWAYS,
                          tgt_true: STEP_COLLECT, tgt_false: STEP_COLLECT};
    endcase
    return w;
  endfunction

  // Stored byte that appears at position i of a reflected header.
  function automatic logic [POS_W-1:0] swapped_index(logic [POS_W-1:0] i);
    logic [POS_W-1:0] r;
    r = i;
    if (i < POS_W'(6)) begin
      r = i + POS_W'(6);
    end else if (i < POS_W'(12)) begin
      r = i - POS_W'(6);
    end else if (i >= POS_W'(26) && i < POS_W'(30)) begin
      r = i + POS_W'(4);
    end else if (i >= POS_W'(30) && i < POS_W'(34)) begin
      r = i - POS_W'(4);
    end else if (i >= POS_W'(34) && i < POS_W'(36)) begin
      r = i + POS_W'(2);
    end else if (i >= POS_W'(36) && i < POS_W'(38)) begin
      r = i - POS_W'(2);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/udp_port_packet_reflector.sv @@
// UDP port packet reflector: top level with frame datapath, register port and sequencer.
// A byte past the header is registered and appears at the output in the cycle after its transfer.
// Header bytes are taken one per cycle; the 42nd byte (or an early frame end) starts a
// burst that replays the held bytes, each by a store read and then an output load.
// Trailing bytes then pass at one per cycle while the output register is not stalled.
// Reset (rst_n low, synchronous) clears position, flags, burst index, sequencer and output
// valid; the header store and captured fields are not cleared; reflect_port returns to 55007.
`default_nettype none

module udp_port_packet_reflector
  import urf_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  // Input byte channel
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire in_item_t          in_data,
  // Result byte channel
  output logic                   out_valid,
  input  wire logic              out_stall,
  output out_item_t              out_data,
  // Configuration port
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [CFG_AW-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output logic      [31:0]       prdata,
  output logic                   pready
);

  // ------------------------------------------------------------------
  // Configuration register. Writes land on the access phase; reads are
  // combinational since pready never drops.
  // ------------------------------------------------------------------
  logic [15:0] reflect_port_r;
  logic        cfg_hit;

  assign pready  = 1'b1;
  assign cfg_hit = paddr[CFG_AW-1:2] == CFG_IDX_REFLECT_PORT;
  assign prdata  = cfg_hit ? {16'd0, reflect_port_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reflect_port_r <= PORT_RESET;
    end else if (psel && penable && pwrite && pready && cfg_hit) begin
      reflect_port_r <= pwdata[15:0];
    end
  end

  // ------------------------------------------------------------------
  // Sequencer. The program has three steps: collect input bytes, read a
  // held header byte, and load it into the output register.
  // ------------------------------------------------------------------
  ctrl_word_t  ctrl;
  seq_status_t status;

  urf_useq u_useq (
    .clk    (clk),
    .rst_n  (rst_n),
    .status (status),
    .ctrl   (ctrl)
  );

  // ------------------------------------------------------------------
  // Frame state
  // ------------------------------------------------------------------
  logic [POS_W-1:0] pos_r, pos_nxt;       // header bytes held so far
  logic             hd_r, hd_nxt;         // header burst already scheduled
  logic             fv_r, fv_nxt;         // verdict for trailing bytes
  logic [7:0]       proto_r;              // captured IPv4 protocol byte
  logic [7:0]       dport_hi_r;           // captured UDP destination port
  logic [7:0]       dport_lo_r;

  // Burst bookkeeping
  logic [POS_W-1:0] cnt_r, cnt_nxt;       // bytes in the burst
  logic [POS_W-1:0] idx_r, idx_nxt;       // burst position being emitted
  logic             bv_r, bv_nxt;         // burst verdict
  logic             bend_r, bend_nxt;     // burst carries the frame end

  // Output register
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_data_r;
  logic             out_free;

  logic             in_xfer;
  logic             hdr_wr;
  logic             go;
  logic             full;
  logic             verdict_now;
  logic             pass_load;
  logic             burst_load;
  logic             last;
  logic [POS_W-1:0] rd_addr;
  logic [7:0]       rd_data;

  assign out_free = !out_valid_r || !out_stall;

  // Input is taken only in the collect step. A trailing byte also needs room in
  // the output register; header bytes only go into the store.
  assign in_stall = !(ctrl.accept && (!hd_r || out_free));
  assign in_xfer  = in_valid && !in_stall;

  assign hdr_wr    = in_xfer && !hd_r;
  assign pass_load = in_xfer && hd_r;
  assign full      = pos_r == OFS_LAST;
  assign go        = hdr_wr && (full || in_data.frame_end);

  // Byte 37 arrives before byte 41, so all three captured bytes are current
  // when the header completes.
  assign verdict_now = full && (proto_r == UDP_PROTO) &&
                       ({dport_hi_r, dport_lo_r} == reflect_port_r);

  assign last       = idx_r == cnt_r - POS_W'(1);
  assign burst_load = ctrl.emit && out_free;

  assign status = '{go: go, last: last, out_free: out_free};

  // ------------------------------------------------------------------
  // Header store
  // ------------------------------------------------------------------
  assign rd_addr = bv_r ? swapped_index(idx_r) : idx_r;

  urf_hdr_mem u_hdr_mem (
    .clk   (clk),
    .we    (hdr_wr),
    .waddr (pos_r),
    .wdata (in_data.frame_byte),
    .re    (ctrl.mem_rd),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (hdr_wr && pos_r == OFS_PROTO) begin
      proto_r <= in_data.frame_byte;
    end
    if (hdr_wr && pos_r == OFS_DPORT_HI) begin
      dport_hi_r <= in_data.frame_byte;
    end
    if (hdr_wr && pos_r == OFS_DPORT_LO) begin
      dport_lo_r <= in_data.frame_byte;
    end
  end

  // ------------------------------------------------------------------
  // Frame and burst control
  // ------------------------------------------------------------------
  always_comb begin
    pos_nxt  = pos_r;
    hd_nxt   = hd_r;
    fv_nxt   = fv_r;
    cnt_nxt  = cnt_r;
    idx_nxt  = idx_r;
    bv_nxt   = bv_r;
    bend_nxt = bend_r;

    if (go) begin
      // The frame state is settled as the burst starts: a frame that ends with
      // the header starts afresh, otherwise trailing bytes follow.
      pos_nxt  = '0;
      hd_nxt   = !in_data.frame_end;
      fv_nxt   = verdict_now && !in_data.frame_end;
      cnt_nxt  = pos_r + POS_W'(1);
      idx_nxt  = '0;
      bv_nxt   = verdict_now;
      bend_nxt = in_data.frame_end;
    end else if (hdr_wr) begin
      pos_nxt = pos_r + POS_W'(1);
    end else if (pass_load && in_data.frame_end) begin
      hd_nxt = 1'b0;
      fv_nxt = 1'b0;
    end

    if (burst_load) begin
      idx_nxt = last ? '0 : idx_r + POS_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      hd_r  <= 1'b0;
      fv_r  <= 1'b0;
      idx_r <= '0;
    end else begin
      pos_r <= pos_nxt;
      hd_r  <= hd_nxt;
      fv_r  <= fv_nxt;
      idx_r <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r  <= cnt_nxt;
    bv_r   <= bv_nxt;
    bend_r <= bend_nxt;
  end

  // ------------------------------------------------------------------
  // Output register. It loads either a trailing byte straight from the
  // input or a replayed header byte from the store.
  // ------------------------------------------------------------------
  always_comb begin
    if (pass_load || burst_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_free) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pass_load) begin
      out_data_r <= '{out_byte: in_data.frame_byte, out_end: in_data.frame_end,
                      verdict: fv_r};
    end else if (burst_load) begin
      out_data_r <= '{out_byte: rd_data, out_end: last && bend_r, verdict: bv_r};
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // ------------------------------------------------------------------
  // Assertions
  // ------------------------------------------------------------------
  a_accept_only_collect: assert property (@(posedge clk) disable iff (!rst_n)
    !in_stall |-> ctrl.accept)
    else $error("input transfer allowed outside the collect step");

  a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r < POS_W'(HDR_LEN))
    else $error("header position ran past the header length");

  a_hd_pos_clear: assert property (@(posedge clk) disable iff (!rst_n)
    hd_r |-> pos_r == '0)
    else $error("header position not cleared while trailing bytes pass");

  a_burst_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.mem_rd || ctrl.emit) |-> idx_r < cnt_r)
    else $error("burst index beyond burst length");

  a_burst_ends: assert property (@(posedge clk) disable iff (!rst_n)
    burst_load && last |=> ctrl.accept && out_valid)
    else $error("final burst byte did not return to collecting");

endmodule

`default_nettype wire

@@ hw/rtl/urf_hdr_mem.sv @@
// Header byte store: one write port, one registered read port.
`default_nettype none

module urf_hdr_mem
  import urf_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [POS_W-1:0] waddr,
  input  wire logic [7:0]       wdata,
  input  wire logic             re,
  input  wire logic [POS_W-1:0] raddr,
  output logic      [7:0]       rdata
);

  logic [7:0] mem [HDR_LEN];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/urf_useq.sv @@
// Microcode sequencer: step counter, control store lookup and conditional jumps.
`default_nettype none

module urf_useq
  import urf_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire seq_status_t status,
  output ctrl_word_t       ctrl
);

  step_t step_r, step_nxt;
  logic  cond_hit;
  logic  hold;

  assign ctrl = ucode_rom(step_r);

  always_comb begin
    unique case (ctrl.cond)
      JC_ALWAYS: cond_hit = 1'b1;
      JC_GO:     cond_hit = status.go;
      JC_LAST:   cond_hit = status.last;
      default:   cond_hit = 1'b1;
    endcase
  end

  // An emit step waits in place until the output register can take the byte.
  assign hold = ctrl.emit && !status.out_free;

  always_comb begin
    if (hold) begin
      step_nxt = step_r;
    end else if (cond_hit) begin
      step_nxt = ctrl.tgt_true;
    end else begin
      step_nxt = ctrl.tgt_false;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= STEP_COLLECT;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule

`default_nettype wire
